/* rtl/core/kng_pkg.sv */
// Shared package for the Kruskal norm block: number-format constants,
// input modes, multiplier operand selects and the controller/datapath structs.
// No dependencies.
`default_nettype none

package kng_pkg;

  // Fixed field and format widths
  localparam int MODE_BITS      = 2;
  localparam int INDEX_BITS     = 4;
  localparam int IN_VALUE_BITS  = 32;
  localparam int RANK_BITS      = 5;
  localparam int FRAC_BITS      = 16;
  localparam int OUT_BITS       = 48;
  localparam int ACC_BITS       = OUT_BITS + 1;
  localparam int SUM_BITS       = OUT_BITS + 3;

  localparam logic [RANK_BITS-1:0] RANK_RESET = 5'd16;
  localparam logic [OUT_BITS-1:0]  ACC_LIM    = '1;

  // Parameter defaults
  localparam int DEF_MAX_RANK   = 16;
  localparam int DEF_VALUE_BITS = 32;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_GRAM   = 2'd1,
    MODE_WEIGHT = 2'd2,
    MODE_NORM   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_GRAM   = 2'd0,
    OP_STAGE1 = 2'd1,
    OP_STAGE2 = 2'd2
  } mul_op_t;

  typedef struct packed {
    logic    sweep_en;
    logic    clr_ovf;
    logic    gram_issue;
    logic    weight_wr;
    logic    cmp_start;
    logic    cmp_rd;
    logic    mul_start;
    mul_op_t mul_op;
    logic    w_rd_j;
    logic    gram_wb;
    logic    mul1_take;
    logic    acc_step;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic gram_hit;
    logic rank_zero;
    logic mul_done;
    logic cmp_last;
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/kng_mul.sv */
// Shared sequential fixed-point multiplier: four half-width partial products,
// then shift by the fraction bits and saturate. Depends on kng_pkg.
`default_nettype none

module kng_mul #(
  parameter int VALUE_BITS = kng_pkg::DEF_VALUE_BITS,
  parameter int OPW        = kng_pkg::DEF_VALUE_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic signed [OPW-1:0]        a,
  input  wire logic signed [OPW-1:0]        b,
  output logic                              done,
  output logic signed [VALUE_BITS-1:0]      result,
  output logic                              sat
);
  import kng_pkg::*;

  localparam int HALF = (OPW + 1) / 2;
  localparam int PW   = 4 * HALF;

  localparam logic [PW-1:0] VMAX_U = (PW'(1) << (VALUE_BITS - 1)) - PW'(1);
  localparam logic signed [VALUE_BITS-1:0] VMAX_S = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VMIN_S = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [2*HALF-1:0] ma;
  logic [2*HALF-1:0] mb;
  logic              neg;
  logic [PW-1:0]     prod;
  logic [1:0]        step;
  logic              busy;
  logic              fin;

  logic [OPW-1:0]      a_mag;
  logic [OPW-1:0]      b_mag;
  logic [HALF-1:0]     part_a;
  logic [HALF-1:0]     part_b;
  logic [2*HALF-1:0]   pp;
  logic [1:0]          sh;
  logic [PW-1:0]       pp_sh;
  logic [PW-1:0]       r;
  logic [PW-1:0]       lim;
  logic [VALUE_BITS-1:0] r_lo;

  assign a_mag  = a[OPW-1] ? -a : a;
  assign b_mag  = b[OPW-1] ? -b : b;
  assign part_a = step[1] ? ma[2*HALF-1:HALF] : ma[HALF-1:0];
  assign part_b = step[0] ? mb[2*HALF-1:HALF] : mb[HALF-1:0];
  assign pp     = (2*HALF)'(part_a) * (2*HALF)'(part_b);
  assign sh     = {1'b0, step[1]} + {1'b0, step[0]};
  assign pp_sh  = PW'(pp) << (HALF * sh);

  assign r    = prod >> FRAC_BITS;
  assign lim  = neg ? (VMAX_U + PW'(1)) : VMAX_U;
  assign r_lo = r[VALUE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Operand latch, partial-product accumulation and saturated result
  always_ff @(posedge clk) begin
    if (start) begin
      ma   <= (2*HALF)'(a_mag);
      mb   <= (2*HALF)'(b_mag);
      neg  <= a[OPW-1] ^ b[OPW-1];
      prod <= '0;
    end else if (busy) begin
      prod <= prod + pp_sh;
    end
    if (fin) begin
      if (r > lim) begin
        result <= neg ? VMIN_S : VMAX_S;
        sat    <= 1'b1;
      end else begin
        result <= neg ? -r_lo : r_lo;
        sat    <= 1'b0;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy && !fin && !done)
    else $error("multiplier started while running");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("multiplier did not start");

  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(fin))
    else $error("multiplier done without final step");

endmodule

`default_nettype wire

/* rtl/core/kng_datapath.sv */
// Datapath: rank register, product and weight memories, index counters,
// multiplier operand selection, accumulator and result register.
// Depends on kng_pkg and kng_mul.
`default_nettype none

module kng_datapath #(
  parameter int MAX_RANK   = kng_pkg::DEF_MAX_RANK,
  parameter int VALUE_BITS = kng_pkg::DEF_VALUE_BITS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire kng_pkg::cmd_t                          cmd,
  output kng_pkg::status_t                            st,
  input  wire logic                                   cfg_we,
  input  wire logic [kng_pkg::RANK_BITS-1:0]          cfg_data,
  input  wire logic [kng_pkg::INDEX_BITS-1:0]         row_index,
  input  wire logic [kng_pkg::INDEX_BITS-1:0]         col_index,
  input  wire logic signed [kng_pkg::IN_VALUE_BITS-1:0] value,
  output logic [kng_pkg::OUT_BITS-1:0]                norm_value,
  output logic                                        saturated
);
  import kng_pkg::*;

  localparam int VB     = VALUE_BITS;
  localparam int OPW    = (VB > FRAC_BITS + 1) ? VB : FRAC_BITS + 2;
  localparam int WIDE   = (VB > IN_VALUE_BITS) ? VB : IN_VALUE_BITS;
  localparam int DEPTH  = MAX_RANK * MAX_RANK;
  localparam int IDX_W  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RANK_W = ($clog2(MAX_RANK + 1) > RANK_BITS) ? $clog2(MAX_RANK + 1)
                                                              : RANK_BITS;

  localparam logic signed [OPW-1:0]  ONE_Q  = OPW'(1) << FRAC_BITS;
  localparam logic signed [WIDE-1:0] VMAX_W = {{(WIDE-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [WIDE-1:0] VMIN_W = ~VMAX_W;
  localparam logic signed [SUM_BITS-1:0] LIM_S  = {{(SUM_BITS-OUT_BITS){1'b0}}, ACC_LIM};
  localparam logic signed [SUM_BITS-1:0] NLIM_S = -LIM_S;

  // Registers
  logic [RANK_BITS-1:0]      rank_reg;
  logic [ADDR_W-1:0]         sw;
  logic                      ovf;
  logic signed [VB-1:0]      val_q;
  logic [ADDR_W-1:0]         g_addr;
  logic [IDX_W-1:0]          ci;
  logic [IDX_W-1:0]          cj;
  logic signed [ACC_BITS-1:0] acc;
  logic                      flag;
  logic signed [OPW-1:0]     pmem [DEPTH];
  logic signed [VB-1:0]      wmem [MAX_RANK];
  logic signed [OPW-1:0]     p_rd;
  logic signed [VB-1:0]      w_rd;

  // Combinational
  logic [RANK_W-1:0]         eff;
  logic [RANK_W-1:0]         rank_m1;
  logic signed [WIDE-1:0]    val_wide;
  logic                      val_ovf;
  logic signed [VB-1:0]      val_clamp;
  logic                      weight_hit;
  logic [ADDR_W-1:0]         in_addr;
  logic [ADDR_W-1:0]         ij_addr;
  logic                      j_end;
  logic signed [OPW-1:0]     mul_a;
  logic signed [OPW-1:0]     mul_b;
  logic                      mul_done;
  logic signed [VB-1:0]      mul_res;
  logic                      mul_sat;
  logic signed [SUM_BITS-1:0] term;
  logic signed [SUM_BITS-1:0] sum;
  logic signed [ACC_BITS-1:0] acc_next;
  logic                      acc_clamp;
  logic signed [ACC_BITS-1:0] acc_neg;

  assign eff = (RANK_W'(rank_reg) < RANK_W'(MAX_RANK)) ? RANK_W'(rank_reg)
                                                        : RANK_W'(MAX_RANK);
  assign rank_m1 = eff - RANK_W'(1);

  assign val_wide  = WIDE'(value);
  assign val_ovf   = (val_wide > VMAX_W) || (val_wide < VMIN_W);
  assign val_clamp = (val_wide > VMAX_W) ? VMAX_W[VB-1:0] :
                     (val_wide < VMIN_W) ? VMIN_W[VB-1:0] : val_wide[VB-1:0];

  assign weight_hit = 32'(row_index) < MAX_RANK;
  assign in_addr    = ADDR_W'(32'(row_index) * MAX_RANK + 32'(col_index));
  assign ij_addr    = ADDR_W'(32'(ci) * MAX_RANK + 32'(cj));
  assign j_end      = RANK_W'(cj) == rank_m1;

  assign st.sweep_last = sw == ADDR_W'(DEPTH - 1);
  assign st.gram_hit   = (row_index <= col_index) && (RANK_W'(col_index) < eff);
  assign st.rank_zero  = eff == '0;
  assign st.mul_done   = mul_done;
  assign st.cmp_last   = (RANK_W'(ci) == rank_m1) && j_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_reg <= RANK_RESET;
    end else if (cfg_we) begin
      rank_reg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw <= '0;
    end else if (cmd.sweep_en) begin
      sw <= st.sweep_last ? '0 : sw + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
    end else if (cmd.clr_ovf) begin
      ovf <= 1'b0;
    end else if ((cmd.gram_issue && val_ovf) || (cmd.weight_wr && weight_hit && val_ovf) ||
                 (cmd.gram_wb && mul_sat)) begin
      ovf <= 1'b1;
    end
  end

  // Product memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.sweep_en) begin
      pmem[sw] <= ONE_Q;
    end else if (cmd.gram_wb) begin
      pmem[g_addr] <= OPW'(mul_res);
    end
    if (cmd.gram_issue) begin
      p_rd <= pmem[in_addr];
    end else if (cmd.cmp_rd) begin
      p_rd <= pmem[ij_addr];
    end
  end

  // Weight memory
  always_ff @(posedge clk) begin
    if (cmd.weight_wr && weight_hit) begin
      wmem[IDX_W'(row_index)] <= val_clamp;
    end
    if (cmd.cmp_rd) begin
      w_rd <= wmem[ci];
    end else if (cmd.w_rd_j) begin
      w_rd <= wmem[cj];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gram_issue) begin
      val_q  <= val_clamp;
      g_addr <= in_addr;
    end
  end

  always_comb begin
    case (cmd.mul_op)
      OP_GRAM: begin
        mul_a = p_rd;
        mul_b = OPW'(val_q);
      end
      OP_STAGE1: begin
        mul_a = p_rd;
        mul_b = OPW'(w_rd);
      end
      OP_STAGE2: begin
        mul_a = OPW'(mul_res);
        mul_b = OPW'(w_rd);
      end
      default: begin
        mul_a = p_rd;
        mul_b = OPW'(w_rd);
      end
    endcase
  end

  kng_mul #(
    .VALUE_BITS (VB),
    .OPW        (OPW)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res),
    .sat    (mul_sat)
  );

  // Off-diagonal terms count twice; clamp the running sum after every add
  assign term = (ci != cj) ? (SUM_BITS'(mul_res) <<< 1) : SUM_BITS'(mul_res);
  assign sum  = SUM_BITS'(acc) + term;

  always_comb begin
    acc_clamp = 1'b1;
    if (sum > LIM_S) begin
      acc_next = LIM_S[ACC_BITS-1:0];
    end else if (sum < NLIM_S) begin
      acc_next = NLIM_S[ACC_BITS-1:0];
    end else begin
      acc_next  = sum[ACC_BITS-1:0];
      acc_clamp = 1'b0;
    end
  end

  assign acc_neg = -acc;

  always_ff @(posedge clk) begin
    if (cmd.cmp_start) begin
      ci   <= '0;
      cj   <= '0;
      acc  <= '0;
      flag <= ovf;
    end else if (cmd.mul1_take) begin
      flag <= flag | mul_sat;
    end else if (cmd.acc_step) begin
      acc  <= acc_next;
      flag <= flag | mul_sat | acc_clamp;
      if (j_end) begin
        ci <= ci + IDX_W'(1);
        cj <= ci + IDX_W'(1);
      end else begin
        cj <= cj + IDX_W'(1);
      end
    end
    if (cmd.out_load) begin
      norm_value <= acc[ACC_BITS-1] ? acc_neg[OUT_BITS-1:0] : acc[OUT_BITS-1:0];
      saturated  <= flag;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/kng_ctrl.sv */
// Controller state machine: input and output handshakes, clearing sweep,
// gram read-modify-write and the triangle walk of a norm compute.
// Depends on kng_pkg.
`default_nettype none

module kng_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [kng_pkg::MODE_BITS-1:0] mode,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  input  wire kng_pkg::status_t             st,
  output kng_pkg::cmd_t                     cmd
);
  import kng_pkg::*;

  typedef enum logic [9:0] {
    S_INIT   = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_GRAM_M = 10'b00_0000_0100,
    S_GRAM_W = 10'b00_0000_1000,
    S_CMP_RD = 10'b00_0001_0000,
    S_CMP_M1 = 10'b00_0010_0000,
    S_CMP_W1 = 10'b00_0100_0000,
    S_CMP_M2 = 10'b00_1000_0000,
    S_CMP_W2 = 10'b01_0000_0000,
    S_FIN    = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    cmd.mul_op = OP_GRAM;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.sweep_en = 1'b1;
        if (st.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (mode_t'(mode))
            MODE_CLEAR: begin
              cmd.clr_ovf = 1'b1;
              state_next  = S_INIT;
            end
            MODE_GRAM: begin
              if (st.gram_hit) begin
                cmd.gram_issue = 1'b1;
                state_next     = S_GRAM_M;
              end
            end
            MODE_WEIGHT: begin
              cmd.weight_wr = 1'b1;
            end
            MODE_NORM: begin
              cmd.cmp_start = 1'b1;
              state_next    = st.rank_zero ? S_FIN : S_CMP_RD;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_GRAM_M: begin
        cmd.mul_start = 1'b1;
        state_next    = S_GRAM_W;
      end
      S_GRAM_W: begin
        if (st.mul_done) begin
          cmd.gram_wb = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_CMP_RD: begin
        cmd.cmp_rd = 1'b1;
        state_next = S_CMP_M1;
      end
      S_CMP_M1: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = OP_STAGE1;
        cmd.w_rd_j    = 1'b1;
        state_next    = S_CMP_W1;
      end
      S_CMP_W1: begin
        cmd.mul_op = OP_STAGE1;
        if (st.mul_done) begin
          cmd.mul1_take = 1'b1;
          state_next    = S_CMP_M2;
        end
      end
      S_CMP_M2: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = OP_STAGE2;
        state_next    = S_CMP_W2;
      end
      S_CMP_W2: begin
        cmd.mul_op = OP_STAGE2;
        if (st.mul_done) begin
          cmd.acc_step = 1'b1;
          state_next   = st.cmp_last ? S_FIN : S_CMP_RD;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_sweep_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_en |-> !in_ready)
    else $error("input accepted during clearing sweep");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result presented outside final state");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    st.mul_done |-> (state == S_GRAM_W) || (state == S_CMP_W1) || (state == S_CMP_W2))
    else $error("multiplier finished while controller not waiting");

endmodule

`default_nettype wire

/* rtl/core/kruskal_norm_gram_hadamard_top.sv */
// Top level of the Kruskal tensor squared-norm block: ties the controller,
// the datapath and its shared multiplier together. Depends on kng_pkg,
// kng_ctrl, kng_datapath and kng_mul.
`default_nettype none

// Squared norm of a Kruskal tensor from the Hadamard product of its factor
// Gram matrices. Items arrive on a valid/ready channel with a mode: clear
// (reset the whole product store to one and drop the sticky
// overflow), gram element (multiply into the store entry at row/col; entries
// below the diagonal or outside the active rank are dropped), column weight
// (load weight row_index), and compute, which walks the upper triangle and
// returns one result item: |sum of P[i][i]*w_i*w_i + 2*P[i][j]*w_i*w_j|,
// unsigned Q32.16 clamped to 48 bits, with a flag for any saturation. Values
// are signed fixed point with 16 fraction bits at VALUE_BITS width. The
// active rank is min(rank_in_use, MAX_RANK); the user must write rank_in_use
// through cfg_we/cfg_data only while the block is idle, which the block
// itself does not enforce. Timing is set by the shared multiplier, which
// forms each product from four half-width partial products, then a
// saturation step and a done strobe. After reset and after every clear item
// a clearing pass writes one into every store entry, during which no item
// is accepted. A finished result waits in an output register, so the next
// item is taken while it is still pending.
module kruskal_norm_gram_hadamard_top #(
  parameter int MAX_RANK   = kng_pkg::DEF_MAX_RANK,
  parameter int VALUE_BITS = kng_pkg::DEF_VALUE_BITS
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  // Configuration: rank_in_use
  input  wire logic                                     cfg_we,
  input  wire logic [kng_pkg::RANK_BITS-1:0]            cfg_data,
  // Input item channel
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic [kng_pkg::MODE_BITS-1:0]            mode,
  input  wire logic [kng_pkg::INDEX_BITS-1:0]           row_index,
  input  wire logic [kng_pkg::INDEX_BITS-1:0]           col_index,
  input  wire logic signed [kng_pkg::IN_VALUE_BITS-1:0] value,
  // Result item channel
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic [kng_pkg::OUT_BITS-1:0]                  norm_value,
  output logic                                          saturated
);
  import kng_pkg::*;

  // Commands down to the datapath, status back to the controller
  cmd_t    cmd;
  status_t st;

  // Controller: owns the handshakes and sequences every item
  kng_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath: memories, counters, multiplier, accumulator, result register
  kng_datapath #(
    .MAX_RANK   (MAX_RANK),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .row_index  (row_index),
    .col_index  (col_index),
    .value      (value),
    .norm_value (norm_value),
    .saturated  (saturated)
  );

endmodule

`default_nettype wire

/* tb/kruskal_norm_gram_hadamard_top_test.sv */
// Self-checking testbench for kruskal_norm_gram_hadamard_top: a queue-fed driver,
// a result monitor and a built-in predictor of the Kruskal squared norm.
// Depends on kng_pkg and the kruskal_norm_gram_hadamard_top RTL.
`default_nettype none

module kruskal_norm_gram_hadamard_top_test;
  import kng_pkg::*;

  localparam int RANK_MAX = DEF_MAX_RANK;
  // Worst quiet stretch: a rank-16 compute plus a clearing pass and output
  // stalls; allow several times that.
  localparam int STALL_LIMIT = 20000;
  // Clearing pass after a clear item plus margin.
  localparam int QUIET_CYCLES = 300;
  localparam int ITEM_TARGET = 1350;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam longint NORM_CEIL = 64'sh0000_FFFF_FFFF_FFFF;

  typedef struct packed {
    mode_t             op;
    logic [3:0]        row;
    logic [3:0]        col;
    logic signed [31:0] value;
  } norm_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] norm;
    logic                sat;
  } norm_result_t;

  typedef struct packed {
    logic               clipped;
    logic signed [31:0] val;
  } qprod_t;

  // Block ports
  logic                             clk;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [RANK_BITS-1:0]             cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [MODE_BITS-1:0]             mode = '0;
  logic [INDEX_BITS-1:0]            row_index = '0;
  logic [INDEX_BITS-1:0]            col_index = '0;
  logic signed [IN_VALUE_BITS-1:0]  value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [OUT_BITS-1:0]              norm_value;
  logic                             saturated;

  // Predictor state: the Hadamard product store, column weights, sticky
  // overflow and the rank setting last written.
  logic signed [31:0]   gram_product [RANK_MAX][RANK_MAX];
  logic signed [31:0]   col_weight [RANK_MAX];
  logic                 sticky_overflow = 1'b0;
  logic [RANK_BITS-1:0] active_rank = RANK_RESET;

  norm_item_t   item_backlog [$];
  norm_result_t norm_expected [$];
  norm_item_t   on_wire;

  logic [RANK_MAX-1:0] weights_loaded = '0;
  int  live_items = 0;
  int  mismatch_count = 0;
  int  results_seen = 0;
  int  stall_cycles = 0;
  bit  steady_flow = 1'b0;

  kruskal_norm_gram_hadamard_top DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .row_index  (row_index),
    .col_index  (col_index),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .norm_value (norm_value),
    .saturated  (saturated)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int eff_rank();
    return (active_rank > RANK_MAX) ? RANK_MAX : int'(active_rank);
  endfunction

  // Q16.16 product: truncate the magnitude toward zero, then clip to 32 bits.
  function automatic qprod_t q_mul(logic signed [31:0] a, logic signed [31:0] b);
    logic        negative;
    logic [63:0] mag_a, mag_b, mag, ceiling;
    qprod_t      r;
    negative = a[31] ^ b[31];
    mag_a = a[31] ? -longint'(a) : longint'(a);
    mag_b = b[31] ? -longint'(b) : longint'(b);
    mag = (mag_a * mag_b) >> FRAC_BITS;
    ceiling = negative ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
    if (mag > ceiling) begin
      r.clipped = 1'b1;
      r.val = negative ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r.clipped = 1'b0;
      r.val = negative ? -mag[31:0] : mag[31:0];
    end
    return r;
  endfunction

  // Apply one accepted item to the predictor; a compute leaves an expectation.
  function automatic void predict_item(norm_item_t it);
    qprod_t       p1, p2;
    norm_result_t res;
    longint       acc, term;
    logic [63:0]  mag_acc;
    int           i, j, r;
    case (it.op)
      MODE_CLEAR: begin
        for (i = 0; i < RANK_MAX; i++)
          for (j = i; j < RANK_MAX; j++)
            gram_product[i][j] = Q_ONE;
        sticky_overflow = 1'b0;
      end
      MODE_GRAM: begin
        if (it.row <= it.col && it.col < eff_rank()) begin
          p1 = q_mul(gram_product[it.row][it.col], it.value);
          gram_product[it.row][it.col] = p1.val;
          sticky_overflow |= p1.clipped;
        end
      end
      MODE_WEIGHT: begin
        col_weight[it.row] = it.value;
      end
      default: begin
        res.sat = sticky_overflow;
        acc = 0;
        r = eff_rank();
        for (i = 0; i < r; i++) begin
          for (j = i; j < r; j++) begin
            p1 = q_mul(gram_product[i][j], col_weight[i]);
            p2 = q_mul(p1.val, col_weight[j]);
            res.sat |= p1.clipped | p2.clipped;
            term = longint'(p2.val);
            if (j != i) term = term * 2;
            acc += term;
            if (acc > NORM_CEIL) begin
              acc = NORM_CEIL;
              res.sat = 1'b1;
            end
            if (acc < -NORM_CEIL) begin
              acc = -NORM_CEIL;
              res.sat = 1'b1;
            end
          end
        end
        mag_acc = (acc < 0) ? -acc : acc;
        res.norm = mag_acc[OUT_BITS-1:0];
        norm_expected.push_back(res);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present the next item whenever the channel is free, idling at
  // random unless a steady stretch is running.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // Predict first, so the item on the wire is not overwritten before use.
      if (in_valid && in_ready) predict_item(on_wire);
      if (!in_valid || in_ready) begin
        if (item_backlog.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 25)) begin
          on_wire = item_backlog.pop_front();
          in_valid  <= 1'b1;
          mode      <= on_wire.op;
          row_index <= on_wire.row;
          col_index <= on_wire.col;
          value     <= on_wire.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check every result against the oldest expectation and stall the
  // result channel at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    norm_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (norm_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: none expected, got norm=%h sat=%b",
                     results_seen, norm_value, saturated);
        end else begin
          want = norm_expected.pop_front();
          if (want.norm !== norm_value || want.sat !== saturated) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result %0d: norm expected %h got %h, sat expected %b got %b",
                       results_seen, want.norm, norm_value, want.sat, saturated);
          end
        end
      end
      out_ready <= steady_flow || ($urandom_range(0, 99) >= 25);
    end
  end

  // Watchdog: end the run if no item moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("FAIL kruskal_norm_gram_hadamard_top");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Queue one item; count it unless the block will drop it. Indexes keep
  // their low four bits.
  function automatic void queue_item(mode_t op, int r, int c, logic [31:0] v);
    norm_item_t it;
    it.op = op;
    it.row = 4'(r);
    it.col = 4'(c);
    it.value = v;
    item_backlog.push_back(it);
    if (op == MODE_WEIGHT) weights_loaded[it.row] = 1'b1;
    if (op != MODE_GRAM || (it.row <= it.col && it.col < eff_rank())) live_items++;
  endfunction

  // Mostly moderate Q16.16 values around +-2.0, with some full-range and
  // boundary values to provoke saturation.
  function automatic logic [31:0] random_value();
    int dice;
    dice = $urandom_range(0, 99);
    if (dice < 88) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    if (dice < 96) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000;
      default: return 32'hFFFF_0000;
    endcase
  endfunction

  // Load every weight not yet written, so no compute reads an empty entry.
  function automatic void ensure_weights();
    int k;
    for (k = 0; k < RANK_MAX; k++)
      if (!weights_loaded[k]) queue_item(MODE_WEIGHT, k, $urandom, random_value());
  endfunction

  // Well-formed run: clear, stream the upper triangle for one to three modes
  // with a few dropped elements mixed in, touch up weights, compute.
  function automatic void queue_sequence();
    int r, modes, m, i, j;
    r = eff_rank();
    modes = (r > 8) ? 1 : $urandom_range(1, 3);
    ensure_weights();
    queue_item(MODE_CLEAR, $urandom, $urandom, $urandom);
    for (m = 0; m < modes; m++) begin
      for (i = 0; i < r; i++) begin
        for (j = i; j < r; j++) begin
          if ($urandom_range(0, 99) < 75) queue_item(MODE_GRAM, i, j, random_value());
          if ($urandom_range(0, 29) == 0) begin
            if (r < RANK_MAX && $urandom_range(0, 1) == 0) begin
              // Beyond the active rank: dropped.
              j = $urandom_range(r, RANK_MAX - 1);
              queue_item(MODE_GRAM, $urandom_range(0, j), j, random_value());
              j = i;
            end else begin
              // Below the diagonal: dropped.
              queue_item(MODE_GRAM, $urandom_range(1, 15), 0, random_value());
            end
          end
        end
      end
    end
    repeat ($urandom_range(0, 3)) queue_item(MODE_WEIGHT, $urandom, $urandom, random_value());
    queue_item(MODE_NORM, $urandom, $urandom, $urandom);
  endfunction

  function automatic void queue_noise();
    mode_t op;
    op = mode_t'($urandom_range(0, 3));
    if (op == MODE_NORM) ensure_weights();
    queue_item(op, $urandom, $urandom, $urandom);
  endfunction

  // Hold until every item is taken and every result is back, then let the
  // longest silent work (a clearing pass) run out.
  task automatic settle();
    do @(negedge clk);
    while (item_backlog.size() != 0 || in_valid || norm_expected.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_rank(logic [RANK_BITS-1:0] r);
    settle();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    cfg_we   <= 1'b0;
    active_rank = r;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase, phase_goal, i, j;
    logic [RANK_BITS-1:0] rank;

    for (i = 0; i < RANK_MAX; i++)
      for (j = 0; j < RANK_MAX; j++)
        gram_product[i][j] = Q_ONE;
    for (i = 0; i < RANK_MAX; i++) col_weight[i] = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part at rank 3: every mode, index and value extremes, dropped
    // elements, a saturating load that leaves the sticky flag, and a clear
    // that drops it again.
    set_rank(5'd3);
    queue_item(MODE_WEIGHT, 0, 0, 32'h0001_0000);
    queue_item(MODE_WEIGHT, 1, 0, 32'hFFFE_8000);
    queue_item(MODE_WEIGHT, 2, 0, 32'h0002_0000);
    queue_item(MODE_WEIGHT, 15, 15, 32'h8000_0000);
    queue_item(MODE_CLEAR, 15, 15, 32'hFFFF_FFFF);
    queue_item(MODE_GRAM, 0, 0, 32'h0002_0000);
    queue_item(MODE_GRAM, 0, 1, 32'hFFFF_8000);
    queue_item(MODE_GRAM, 1, 2, 32'h0003_0000);
    queue_item(MODE_GRAM, 1, 0, 32'h7FFF_FFFF);
    queue_item(MODE_GRAM, 0, 3, 32'h0005_0000);
    queue_item(MODE_GRAM, 15, 15, 32'hFFFF_FFFF);
    queue_item(MODE_NORM, 0, 0, 32'h0000_0000);
    queue_item(MODE_GRAM, 2, 2, 32'h7FFF_FFFF);
    queue_item(MODE_GRAM, 2, 2, 32'h8000_0000);
    queue_item(MODE_NORM, 15, 15, 32'h0000_0000);
    queue_item(MODE_CLEAR, 0, 0, 32'h0000_0000);
    queue_item(MODE_WEIGHT, 0, 0, 32'h7FFF_FFFF);
    queue_item(MODE_WEIGHT, 1, 0, 32'h8000_0000);
    queue_item(MODE_GRAM, 0, 1, 32'h0000_0000);
    queue_item(MODE_NORM, 0, 0, 32'hFFFF_FFFF);
    queue_item(MODE_WEIGHT, 2, 0, 32'h0000_0000);
    queue_item(MODE_NORM, 0, 0, 32'h0000_0000);

    // Random part in phases; each phase boundary holds the sender until all
    // results are back, then moves to a new rank. The first phases take the
    // extremes; one phase runs with no idling on either side.
    live_items = 0;
    phase = 0;
    while (live_items < ITEM_TARGET) begin
      case (phase)
        0: rank = 5'd31;
        1: rank = 5'd0;
        2: rank = 5'd1;
        3: rank = 5'd16;
        default: rank = ($urandom_range(0, 7) == 0) ? 5'd16 : 5'($urandom_range(2, 8));
      endcase
      set_rank(rank);
      steady_flow = (phase == 4);
      phase_goal = live_items + 110;
      while (live_items < phase_goal) begin
        if ($urandom_range(0, 99) < 80) queue_sequence();
        else queue_noise();
      end
      phase++;
    end

    settle();
    if (mismatch_count == 0)
      $display("PASS kruskal_norm_gram_hadamard_top");
    else
      $display("FAIL kruskal_norm_gram_hadamard_top");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/core/kng_pkg.sv
rtl/core/kng_mul.sv
rtl/core/kng_datapath.sv
rtl/core/kng_ctrl.sv
rtl/core/kruskal_norm_gram_hadamard_top.sv
tb/kruskal_norm_gram_hadamard_top_test.sv
